// File: rtl/c3rf_pkg.sv
// c3rf_pkg: shared types, constants and register indexes for the 3x3 reflect filter
// no dependencies
package c3rf_pkg;

  localparam int MaxLine = 2048;
  localparam int LineAw = $clog2(MaxLine);
  localparam int NumCh = 3;
  localparam int PixMax = 255;

  localparam logic [2:0] RegCoefTop = 3'd0;
  localparam logic [2:0] RegCoefMid = 3'd1;
  localparam logic [2:0] RegCoefBot = 3'd2;
  localparam logic [2:0] RegScale = 3'd3;
  localparam logic [2:0] RegWidth = 3'd4;
  localparam logic [2:0] RegHeight = 3'd5;
  localparam logic [2:0] RegChCount = 3'd6;

  typedef struct packed {
    logic [7:0] in_ch2;
    logic [7:0] in_ch1;
    logic [7:0] in_ch0;
  } pix_in_t;

  typedef struct packed {
    logic       frame_done;
    logic       last_of_run;
    logic [7:0] out_ch2;
    logic [7:0] out_ch1;
    logic [7:0] out_ch0;
  } pix_out_t;

  // one 3x3 window of one channel, [row][col]
  typedef logic [2:0][2:0][7:0] win_t;

  // window job handed to the lanes
  typedef struct packed {
    logic       last_of_run;
    logic       frame_done;
    logic [1:0] nch;
    logic [NumCh-1:0][2:0][2:0][7:0] win;
  } job_t;

endpackage

// File: rtl/conv3x3_reflect_pixel_filter.sv
// conv3x3_reflect_pixel_filter: top level, config registers, lanes and output merge
// depends on c3rf_pkg, c3rf_window, c3rf_lane
//
// Usage: pixels enter in raster order on in_valid_i/in_stall_o, one transfer per
// pixel. Results leave on out_valid_o/out_stall_i. Output pixel (R,C) comes out
// when input (R+1,C+1) arrives; the last column follows its left neighbour, and
// the last two rows come out together during the final input row. One input
// causes 0, 1, 2 or 4 results.
// Throughput: an input is not taken until every result of the previous input has
// left; its jobs pass the store access, the sequencer (one job per cycle while
// the output does not stall), the lane pipeline and the output register in turn.
// The store read-modify-write and the shared window sequencer limit throughput.
// Three lanes, one per channel, each do multiply, adder tree and scale in three
// registered stages; the merge stage packs them into one result word.
// Reset clears counters, window and config to their defaults; line stores are
// not cleared. While out_stall_i holds a valid result the lane pipeline and sequencer hold
// and in_stall_o stays high until the pending results have left.
// The user must write configuration on cfg_we_i only while idle; the block does not enforce it.
module conv3x3_reflect_pixel_filter
  import c3rf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pix_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pix_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  logic [2:0][47:0]   coef_q;
  logic signed [31:0] scale_q;
  logic [11:0]        width_q;
  logic [15:0]        height_q;
  logic [1:0]         nch_q;
  logic               pos_clr;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= '0;
      coef_q[1] <= 48'h0000_0100_0000;
      coef_q[2] <= '0;
      scale_q <= 32'sd65536;
      width_q <= 12'd1920;
      height_q <= 16'd1080;
      nch_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoefTop: coef_q[0] <= cfg_data_i;
        RegCoefMid: coef_q[1] <= cfg_data_i;
        RegCoefBot: coef_q[2] <= cfg_data_i;
        RegScale:   scale_q <= cfg_data_i[31:0];
        RegWidth:   width_q <= cfg_data_i[11:0];
        RegHeight:  height_q <= cfg_data_i[15:0];
        RegChCount: nch_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign pos_clr = cfg_we_i && (cfg_idx_i == RegWidth || cfg_idx_i == RegHeight);

  // pipeline: 3 lane stages then output register
  logic        en;
  logic [3:0]  vld_q;
  logic [2:0][1:0] tag_q;
  logic        job_valid, busy, in_fire;
  job_t        job;
  logic [NumCh-1:0][7:0] lane_pix;

  assign en = !(out_valid_o && out_stall_i);
  assign in_fire = in_valid_i && !in_stall_o;
  assign in_stall_o = busy || (|vld_q);

  c3rf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_pix_i    (in_data_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .nch_i       (nch_q),
    .pos_clr_i   (pos_clr),
    .job_take_i  (en),
    .job_valid_o (job_valid),
    .job_o       (job),
    .busy_o      (busy)
  );

  for (genvar g = 0; g < NumCh; g++) begin : g_lane
    c3rf_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .win_i   (job.win[g]),
      .coef_i  (coef_q),
      .scale_i (scale_q),
      .use_i   (2'(g) < job.nch),
      .pix_o   (lane_pix[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], job_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q <= {tag_q[1:0], {job.last_of_run, job.frame_done}};
    end
  end

  // merge stage: output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.out_ch0 <= lane_pix[0];
      out_data_o.out_ch1 <= lane_pix[1];
      out_data_o.out_ch2 <= lane_pix[2];
      out_data_o.last_of_run <= tag_q[2][1];
      out_data_o.frame_done <= tag_q[2][0];
    end
  end

  assign out_valid_o = vld_q[3];

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // frame end is always the last result of its input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.last_of_run)
    else $error("frame_done without last_of_run");

  // no input while results of an earlier one are in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !job_valid && vld_q == 4'd0)
    else $error("input accepted while busy");

endmodule

// File: rtl/c3rf_lane.sv
// c3rf_lane: one channel lane, 3x3 multiply-accumulate, scale, truncate and clamp
// depends on c3rf_pkg
module c3rf_lane
  import c3rf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  win_t                  win_i,
  input  logic [2:0][47:0]      coef_i,
  input  logic signed [31:0]    scale_i,
  input  logic                  use_i,
  output logic [7:0]            pix_o
);

  logic signed [8:0][24:0] prod_d;
  logic signed [8:0][24:0] prod_q;
  logic signed [28:0]      sum_d;
  logic signed [28:0]      sum_q;
  logic signed [60:0]      mul_d;
  logic signed [60:0]      mul_q;
  logic [2:0]              use_q;

  // stage 1: nine 8x16 products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i*3+j] = 25'($signed({1'b0, win_i[i][j]}) * $signed(coef_i[i][16*j +: 16]));
      end
    end
  end

  // stage 2: adder tree, each product sign extended
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 9; k++) begin
      sum_d = sum_d + 29'($signed(prod_q[k]));
    end
  end

  // stage 3: scale multiply (29x32)
  assign mul_d = 61'(sum_q) * 61'(scale_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      mul_q  <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      use_q <= {use_q[1:0], use_i};
    end
  end

  // truncate toward zero and clamp
  always_comb begin
    if (!use_q[2] || mul_q <= 0) begin
      pix_o = '0;
    end else if (mul_q[60:24] > 37'(PixMax)) begin
      pix_o = 8'(PixMax);
    end else begin
      pix_o = mul_q[31:24];
    end
  end

endmodule

// File: rtl/c3rf_window.sv
// c3rf_window: line stores, window registers, position counters and border reflection
// depends on c3rf_pkg
module c3rf_window
  import c3rf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_fire_i,
  input  pix_in_t      in_pix_i,
  input  logic [11:0]  width_i,
  input  logic [15:0]  height_i,
  input  logic [1:0]   nch_i,
  input  logic         pos_clr_i,
  input  logic         job_take_i,
  output logic         job_valid_o,
  output job_t         job_o,
  output logic         busy_o
);

  // stores, read data registered
  logic [23:0] store_up [MaxLine];
  logic [23:0] store_lo [MaxLine];
  logic [23:0] rd_up_q, rd_lo_q, px_q;
  logic [LineAw-1:0] addr;

  logic [15:0] row_q, row_d;
  logic [11:0] col_q, col_d;
  logic [2:0][47:0] wreg_q;
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic [1:0]  nch_eff;

  // stage-2 context
  logic        s2_q;
  logic [15:0] r2_q;
  logic [11:0] c2_q;
  logic [11:0] w2_q;
  logic [15:0] h2_q;
  logic [1:0]  nch2_q;

  // job sequencer
  logic        run_q;
  logic [1:0]  idx_q;
  logic [1:0]  cnt_q;
  logic [2:0][23:0] cur_q, p1_q, p2_q;
  logic        c1_q, last_row_q, fd_q;
  logic [1:0]  nchj_q;
  logic        row_is_one;
  logic        col_last, row_last;

  logic [2:0][23:0] cur;

  always_comb begin
    if (width_i < 12'd2) begin
      w_eff = 12'd2;
    end else if (width_i > 12'(MaxLine)) begin
      w_eff = 12'(MaxLine);
    end else begin
      w_eff = width_i;
    end
    h_eff = (height_i < 16'd2) ? 16'd2 : height_i;
    nch_eff = nch_i;
  end

  // position, wrapped when beyond the image
  logic [11:0] c_use;
  logic [15:0] r_use;
  always_comb begin
    if (col_q >= w_eff || row_q >= h_eff) begin
      c_use = '0;
      r_use = '0;
    end else begin
      c_use = col_q;
      r_use = row_q;
    end
    addr = c_use[LineAw-1:0];
    if (c_use + 12'd1 >= w_eff) begin
      col_d = '0;
      row_d = (r_use + 16'd1 >= h_eff) ? 16'd0 : r_use + 16'd1;
    end else begin
      col_d = c_use + 12'd1;
      row_d = r_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (pos_clr_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // store read and write
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      rd_up_q <= store_up[addr];
      rd_lo_q <= store_lo[addr];
      store_lo[addr] <= in_pix_i;
      px_q <= in_pix_i;
      r2_q <= r_use;
      c2_q <= c_use;
      w2_q <= w_eff;
      h2_q <= h_eff;
      nch2_q <= nch_eff;
    end
  end

  // upper store takes the old lower row; read-before-write gives it next cycle
  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      store_up[c2_q[LineAw-1:0]] <= rd_lo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
    end else begin
      s2_q <= in_fire_i;
    end
  end

  assign cur = {px_q, rd_lo_q, rd_up_q};

  // extra passes: last column and last row
  assign col_last = (c2_q == w2_q - 12'd1);
  assign row_last = (r2_q == h2_q - 16'd1);

  // window shift and job capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= '0;
      run_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (s2_q) begin
        for (int i = 0; i < 3; i++) begin
          wreg_q[i] <= {wreg_q[i][23:0], cur[i]};
        end
        if (r2_q >= 16'd1 && c2_q >= 12'd1) begin
          run_q <= 1'b1;
          idx_q <= '0;
          cnt_q <= {col_last && row_last, col_last || row_last};
        end
      end else if (run_q && job_take_i) begin
        if (idx_q == cnt_q) begin
          run_q <= 1'b0;
        end
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= cur[i];
        p1_q[i] <= wreg_q[i][23:0];
        p2_q[i] <= wreg_q[i][47:24];
      end
      c1_q <= (c2_q == 12'd1);
      last_row_q <= row_last;
      fd_q <= row_last && col_last;
      nchj_q <= nch2_q;
    end
  end

  // job decode: on the last row, idx bit1 = last-column pass, bit0 = final-row pass
  logic col_pass, row_pass;
  logic [2:0][23:0] k0, k1, k2;
  logic [1:0] rsel [3];
  logic [1:0] step;
  always_comb begin
    // map job index to (col_pass,row_pass) given which passes exist
    step = idx_q;
    if (last_row_q) begin
      col_pass = step[1];
      row_pass = step[0];
    end else begin
      col_pass = step[0];
      row_pass = 1'b0;
    end
    if (!col_pass) begin
      k0 = c1_q ? cur_q : p2_q;
      k1 = p1_q;
      k2 = cur_q;
    end else begin
      k0 = p1_q;
      k1 = cur_q;
      k2 = p1_q;
    end
    if (!row_pass) begin
      rsel[0] = (row_is_one) ? 2'd2 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = 2'd2;
    end else begin
      rsel[0] = 2'd1;
      rsel[1] = 2'd2;
      rsel[2] = 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      row_is_one <= (r2_q == 16'd1);
    end
  end

  always_comb begin
    job_o.nch = nchj_q;
    job_o.last_of_run = (idx_q == cnt_q);
    job_o.frame_done = fd_q && (idx_q == cnt_q);
    for (int ch = 0; ch < NumCh; ch++) begin
      for (int i = 0; i < 3; i++) begin
        job_o.win[ch][i][0] = k0[rsel[i]][8*ch +: 8];
        job_o.win[ch][i][1] = k1[rsel[i]][8*ch +: 8];
        job_o.win[ch][i][2] = k2[rsel[i]][8*ch +: 8];
      end
    end
  end

  assign job_valid_o = run_q && !s2_q;
  assign busy_o = run_q || s2_q;

endmodule
